// File: hdl/vt4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_pkg: shared types and constants of the vertex transform block
// Fixed-point format, matrix register layout, lane and pipeline types.
// ----------------------------------------------------------------------------
package vt4_pkg;

   // Signed fixed-point format of every entry, component and result.
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;

   // Lane arithmetic widths: a 32x32 product, a pair sum and the full sum.
   localparam int PROD_W    = 2 * DATA_W;
   localparam int PAIR_W    = PROD_W + 1;
   localparam int SUM_W     = PROD_W + 2;

   // Matrix geometry: one lane per row, one product per column.
   localparam int NUM_LANES = 4;
   localparam int NUM_COLS  = 4;
   localparam int NUM_PAIRS = NUM_COLS / 2;

   // Pipeline depth from acceptance to the result register.
   localparam int NUM_STAGES = 4;

   // Configuration registers: two matrix entries per 64-bit register.
   localparam int REG_COUNT     = 8;
   localparam int CSR_DATA_W    = 64;
   localparam int REG_ADDR_LSB  = 3;
   localparam int REG_IDX_W     = $clog2(REG_COUNT);
   localparam int CSR_ADDR_W    = REG_ADDR_LSB + REG_IDX_W;
   localparam int COLS_PER_REG  = CSR_DATA_W / DATA_W;

   // Dimension codes carried by the dims field.
   localparam int DIMS_W = 3;
   typedef logic [DIMS_W-1:0] dims_type;
   localparam dims_type DIMS_MIN = DIMS_W'(2);
   localparam dims_type DIMS_MAX = DIMS_W'(4);

   typedef logic signed [DATA_W-1:0] entry_type;
   typedef entry_type row_type [NUM_COLS];
   typedef row_type matrix_type [NUM_LANES];
   typedef logic [CSR_DATA_W-1:0] csr_word_type;

   // Saturation limits of a result.
   localparam entry_type SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam entry_type SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // The reset matrix is the identity.
   localparam csr_word_type REG_RESET [REG_COUNT] = '{
      64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
   };

   // Load enables of the pipeline stages, one per stage.
   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
   } pipe_ctrl_type;

   // What one lane reports for its row.
   typedef struct packed {
      entry_type value;
      logic      ovf;
   } lane_result_type;

   // Out-of-range dims values act as the nearest legal one.
   function automatic dims_type clamp_dims(input dims_type dims);
      dims_type n;
      n = dims;
      if (dims < DIMS_MIN) begin
         n = DIMS_MIN;
      end else if (dims > DIMS_MAX) begin
         n = DIMS_MAX;
      end
      return n;
   endfunction

endpackage

// File: hdl/vt4_ifaces.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_ifaces: stream channels of the vertex transform block
// Vector request channel and transformed result channel, valid/ready.
// ----------------------------------------------------------------------------
interface vt4_req_if;
   import vt4_pkg::*;
   logic      valid;
   logic      ready;
   entry_type vec_x;
   entry_type vec_y;
   entry_type vec_z;
   entry_type vec_w;
   dims_type  dims;

   modport source (output valid, vec_x, vec_y, vec_z, vec_w, dims, input ready);
   modport sink   (input valid, vec_x, vec_y, vec_z, vec_w, dims, output ready);
endinterface

interface vt4_rsp_if;
   import vt4_pkg::*;
   logic      valid;
   logic      ready;
   entry_type out_x;
   entry_type out_y;
   entry_type out_z;
   entry_type out_w;
   logic      overflow;

   modport source (output valid, out_x, out_y, out_z, out_w, overflow, input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_w, overflow, output ready);
endinterface

// File: hdl/vertex_transform_4x4_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_4x4_top: 4x4 matrix times vector in signed Q16.16
// Computes y = M * v for one vector per word, with 2x2, 3x3 or 4x4 forms.
// ----------------------------------------------------------------------------
// The block takes one vector word every clock cycle unless its full pipeline
// stalls, and passes each word through a product stage, a pair-sum stage, a
// full-sum stage and the result register. Each of the four row lanes has its
// own four 32x32 multipliers, so sixteen multipliers run in parallel and
// nothing is shared between words. Each stage holds its word until the next
// one can take it, so bubbles close up while the result channel stalls.
// The matrix is written through the APB-style port at byte address 8*i and
// must only be changed while no word is in flight.
// ----------------------------------------------------------------------------
module vertex_transform_4x4_top
   import vt4_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   vt4_req_if.sink               req_chan,
   vt4_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  csr_word_type          pwdata,
   output csr_word_type          prdata,
   output logic                  pready
);

   matrix_type            matrix;
   row_type               vec_masked;
   entry_type             vec_raw [NUM_COLS];
   dims_type              dims_req;
   pipe_ctrl_type         pipe_ctrl;
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   dims_type              dims_ff [NUM_STAGES-1];
   dims_type              dims_in [NUM_STAGES-1];
   lane_result_type       lane_res [NUM_LANES];
   entry_type             out_val [NUM_LANES];
   logic                  out_ovf;

   // Matrix registers.
   vt4_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .matrix  (matrix)
   );

   // Components beyond the selected form enter the lanes as zero.
   assign dims_req   = clamp_dims(req_chan.dims);
   assign vec_raw[0] = req_chan.vec_x;
   assign vec_raw[1] = req_chan.vec_y;
   assign vec_raw[2] = req_chan.vec_z;
   assign vec_raw[3] = req_chan.vec_w;

   always_comb begin
      for (int c = 0; c < NUM_COLS; c++) begin
         vec_masked[c] = (DIMS_W'(c) < dims_req) ? vec_raw[c] : '0;
      end
   end

   // A stage loads when it is empty or when its word moves on.
   always_comb begin
      pipe_ctrl.en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_chan.ready;
      for (int s = NUM_STAGES - 2; s >= 0; s--) begin
         pipe_ctrl.en[s] = !valid_ff[s] || pipe_ctrl.en[s+1];
      end
   end

   assign req_chan.ready = pipe_ctrl.en[0];

   // Stage valid flags and the dims code that travels with each word.
   always_comb begin
      valid_in[0] = req_chan.valid;
      dims_in[0]  = dims_req;
      for (int s = 1; s < NUM_STAGES; s++) begin
         valid_in[s] = valid_ff[s-1];
      end
      for (int s = 1; s < NUM_STAGES - 1; s++) begin
         dims_in[s] = dims_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < NUM_STAGES; s++) begin
            if (pipe_ctrl.en[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NUM_STAGES - 1; s++) begin
         if (pipe_ctrl.en[s]) begin
            dims_ff[s] <= dims_in[s];
         end
      end
   end

   // One lane per matrix row.
   for (genvar r = 0; r < NUM_LANES; r++) begin : g_lane
      vt4_lane u_lane (
         .clock  (clock),
         .row    (matrix[r]),
         .vec    (vec_masked),
         .ctrl   (pipe_ctrl),
         .result (lane_res[r])
      );
   end

   // Result register.
   vt4_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (pipe_ctrl),
      .dims     (dims_ff[NUM_STAGES-2]),
      .lane_res (lane_res),
      .out_val  (out_val),
      .overflow (out_ovf)
   );

   assign rsp_chan.valid    = valid_ff[NUM_STAGES-1];
   assign rsp_chan.out_x    = out_val[0];
   assign rsp_chan.out_y    = out_val[1];
   assign rsp_chan.out_z    = out_val[2];
   assign rsp_chan.out_w    = out_val[3];
   assign rsp_chan.overflow = out_ovf;

   // An accepted word occupies the first stage on the next cycle.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> valid_ff[0])
      else $error("accepted word did not enter the pipeline");

   // A stalled word in the sum stage is never dropped.
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NUM_STAGES-2] && !pipe_ctrl.en[NUM_STAGES-1] |=> valid_ff[NUM_STAGES-2])
      else $error("stalled word lost in the sum stage");

   // An empty first stage always takes a word.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[0] |-> req_chan.ready)
      else $error("input not ready with an empty first stage");

endmodule

// File: hdl/vt4_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_csr: matrix register file behind the APB-style port
// Eight 64-bit registers, two Q16.16 entries each, unpacked into the matrix.
// ----------------------------------------------------------------------------
module vt4_csr
   import vt4_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  csr_word_type          pwdata,
   output csr_word_type          prdata,
   output logic                  pready,
   output matrix_type            matrix
);

   csr_word_type         reg_ff [REG_COUNT];
   csr_word_type         reg_in [REG_COUNT];
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:REG_ADDR_LSB];
   assign wr_en   = psel && penable && pwrite;
   assign prdata  = reg_ff[reg_idx];

   // A write replaces the addressed register.
   always_comb begin
      for (int i = 0; i < REG_COUNT; i++) begin
         reg_in[i] = (wr_en && (reg_idx == REG_IDX_W'(i))) ? pwdata : reg_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            reg_ff[i] <= REG_RESET[i];
         end
      end else begin
         for (int i = 0; i < REG_COUNT; i++) begin
            reg_ff[i] <= reg_in[i];
         end
      end
   end

   // Row r, column c sits in register 2r + c/2, lower column in the low half.
   always_comb begin
      for (int r = 0; r < NUM_LANES; r++) begin
         for (int c = 0; c < NUM_COLS; c++) begin
            matrix[r][c] = reg_ff[r * (NUM_COLS / COLS_PER_REG) + c / COLS_PER_REG]
                                 [(c % COLS_PER_REG) * DATA_W +: DATA_W];
         end
      end
   end

endmodule

// File: hdl/vt4_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_lane: one row dot product
// Four parallel products, a pair-sum stage, a full sum, then shift and
// saturation of the exact sum to a 32-bit result.
// ----------------------------------------------------------------------------
module vt4_lane
   import vt4_pkg::*;
(
   input  logic            clock,
   input  row_type         row,
   input  row_type         vec,
   input  pipe_ctrl_type   ctrl,
   output lane_result_type result
);

   logic signed [PROD_W-1:0] prod_ff  [NUM_COLS];
   logic signed [PROD_W-1:0] prod_in  [NUM_COLS];
   logic signed [PAIR_W-1:0] pair_ff  [NUM_PAIRS];
   logic signed [PAIR_W-1:0] pair_in  [NUM_PAIRS];
   logic signed [SUM_W-1:0]  total_ff;
   logic signed [SUM_W-1:0]  total_in;
   logic signed [SUM_W-1:0]  shifted;
   logic [SUM_W-DATA_W:0]    upper;
   logic                     fits;

   // First stage: one signed 32x32 product per column.
   always_comb begin
      for (int c = 0; c < NUM_COLS; c++) begin
         prod_in[c] = PROD_W'(row[c]) * PROD_W'(vec[c]);
      end
   end

   // Second stage: products added in pairs.
   always_comb begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
         pair_in[p] = PAIR_W'(prod_ff[2*p]) + PAIR_W'(prod_ff[2*p+1]);
      end
   end

   // Third stage: the exact row sum.
   always_comb begin
      total_in = '0;
      for (int p = 0; p < NUM_PAIRS; p++) begin
         total_in = total_in + SUM_W'(pair_ff[p]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[0]) begin
         prod_ff <= prod_in;
      end
      if (ctrl.en[1]) begin
         pair_ff <= pair_in;
      end
      if (ctrl.en[2]) begin
         total_ff <= total_in;
      end
   end

   // The arithmetic shift rounds toward minus infinity; the result fits when
   // every bit above the 32-bit sign agrees with it.
   assign shifted = total_ff >>> FRAC_BITS;
   assign upper   = shifted[SUM_W-1:DATA_W-1];
   assign fits    = (upper == '0) || (upper == '1);

   always_comb begin
      result.ovf = !fits;
      if (fits) begin
         result.value = shifted[DATA_W-1:0];
      end else if (total_ff[SUM_W-1]) begin
         result.value = SAT_MIN;
      end else begin
         result.value = SAT_MAX;
      end
   end

endmodule

// File: hdl/vt4_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_merge: result register fed by the four lanes
// Zeroes the rows outside the selected form and gathers the overflow flags
// of the active rows into one.
// ----------------------------------------------------------------------------
module vt4_merge
   import vt4_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  pipe_ctrl_type   ctrl,
   input  dims_type        dims,
   input  lane_result_type lane_res [NUM_LANES],
   output entry_type       out_val  [NUM_LANES],
   output logic            overflow
);

   entry_type out_ff [NUM_LANES];
   entry_type out_in [NUM_LANES];
   logic      overflow_ff;
   logic      overflow_in;

   // Row r is active when it lies inside the dims-by-dims part of the matrix.
   always_comb begin
      overflow_in = 1'b0;
      for (int r = 0; r < NUM_LANES; r++) begin
         if (DIMS_W'(r) < dims) begin
            out_in[r]   = lane_res[r].value;
            overflow_in = overflow_in | lane_res[r].ovf;
         end else begin
            out_in[r]   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_LANES; r++) begin
            out_ff[r] <= '0;
         end
         overflow_ff <= 1'b0;
      end else if (ctrl.en[NUM_STAGES-1]) begin
         out_ff      <= out_in;
         overflow_ff <= overflow_in;
      end
   end

   assign out_val  = out_ff;
   assign overflow = overflow_ff;

   // The 2x2 form leaves the last two rows at zero.
   a_small_form_zero: assert property (@(posedge clock) disable iff (reset)
      ctrl.en[NUM_STAGES-1] && (dims == DIMS_MIN) |=>
         (out_ff[2] == '0) && (out_ff[3] == '0))
      else $error("inactive rows not zero in 2x2 form");

   // Overflow is only reported together with a saturated result.
   a_ovf_has_sat: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |->
         (out_ff[0] == SAT_MAX) || (out_ff[0] == SAT_MIN) ||
         (out_ff[1] == SAT_MAX) || (out_ff[1] == SAT_MIN) ||
         (out_ff[2] == SAT_MAX) || (out_ff[2] == SAT_MIN) ||
         (out_ff[3] == SAT_MAX) || (out_ff[3] == SAT_MIN))
      else $error("overflow flagged without a saturated row");

endmodule

// File: dv/vt4_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_tb_pkg: word types and result scoreboard for the vertex transform bench
// Holds a shadow copy of the matrix registers and predicts y = M * v for each
// accepted vector word, then checks result words in order against it.
// ----------------------------------------------------------------------------
package vt4_tb_pkg;
   import vt4_pkg::*;

   // Matrix registers in address order, two entries per register.
   typedef enum int {
      REG_ROW0_COLS01,
      REG_ROW0_COLS23,
      REG_ROW1_COLS01,
      REG_ROW1_COLS23,
      REG_ROW2_COLS01,
      REG_ROW2_COLS23,
      REG_ROW3_COLS01,
      REG_ROW3_COLS23
   } matrix_reg_e;

   // Range of a result before saturation, at the width of the exact sum.
   localparam logic signed [127:0] SUM_CEIL  = 128'sd2147483647;
   localparam logic signed [127:0] SUM_FLOOR = -128'sd2147483648;

   typedef struct {
      entry_type vec_x;
      entry_type vec_y;
      entry_type vec_z;
      entry_type vec_w;
      dims_type  dims;
   } vector_word_t;

   typedef struct {
      entry_type out_x;
      entry_type out_y;
      entry_type out_z;
      entry_type out_w;
      logic      overflow;
   } result_word_t;

   class transform_scoreboard;
      csr_word_type matrix_regs [REG_COUNT];
      result_word_t expected_results [$];
      int unsigned  failures;

      function new();
         matrix_regs = REG_RESET;
         failures    = 0;
      endfunction

      function void set_matrix_reg(matrix_reg_e idx, csr_word_type value);
         matrix_regs[int'(idx)] = value;
      endfunction

      // The even column sits in the low half of a register, the odd one above.
      function entry_type matrix_entry(int row, int col);
         csr_word_type pair;
         pair = matrix_regs[2 * row + col / 2];
         return (col % 2 == 1) ? entry_type'(pair[63:32]) : entry_type'(pair[31:0]);
      endfunction

      // Exact dot product per active row, floor shift, then saturation.
      function result_word_t transform_vector(vector_word_t v);
         entry_type           comps [NUM_COLS];
         entry_type           lanes [NUM_LANES];
         logic signed [127:0] acc;
         logic signed [127:0] wide_m;
         logic signed [127:0] wide_v;
         int                  n;
         result_word_t        res;
         n = int'(v.dims);
         if (n < int'(DIMS_MIN)) begin
            n = int'(DIMS_MIN);
         end else if (n > int'(DIMS_MAX)) begin
            n = int'(DIMS_MAX);
         end
         comps = '{v.vec_x, v.vec_y, v.vec_z, v.vec_w};
         res.overflow = 1'b0;
         for (int row = 0; row < NUM_LANES; row++) begin
            lanes[row] = '0;
            if (row < n) begin
               acc = '0;
               for (int col = 0; col < n; col++) begin
                  wide_m = matrix_entry(row, col);
                  wide_v = comps[col];
                  acc    = acc + wide_m * wide_v;
               end
               acc = acc >>> FRAC_BITS;
               if (acc > SUM_CEIL) begin
                  lanes[row]   = SAT_MAX;
                  res.overflow = 1'b1;
               end else if (acc < SUM_FLOOR) begin
                  lanes[row]   = SAT_MIN;
                  res.overflow = 1'b1;
               end else begin
                  lanes[row] = entry_type'(acc[31:0]);
               end
            end
         end
         res.out_x = lanes[0];
         res.out_y = lanes[1];
         res.out_z = lanes[2];
         res.out_w = lanes[3];
         return res;
      endfunction

      function void note_vector(vector_word_t v);
         expected_results.push_back(transform_vector(v));
      endfunction

      function void compare_field(string name, logic [31:0] expected, logic [31:0] actual);
         if (expected !== actual) begin
            $error("%s mismatch: expected %h, actual %h", name, expected, actual);
            failures++;
         end
      endfunction

      function void check_result(result_word_t got);
         result_word_t want;
         if (expected_results.size() == 0) begin
            $error("result word arrived with no vector pending");
            failures++;
            return;
         end
         want = expected_results.pop_front();
         compare_field("out_x", want.out_x, got.out_x);
         compare_field("out_y", want.out_y, got.out_y);
         compare_field("out_z", want.out_z, got.out_z);
         compare_field("out_w", want.out_w, got.out_w);
         compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void check_drained();
         if (expected_results.size() != 0) begin
            $error("%0d result words never arrived", expected_results.size());
            failures++;
         end
      endfunction
   endclass

endpackage

// File: dv/tb_vertex_transform_4x4_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_transform_4x4_top: self-checking bench of the 4x4 vertex transform
// Writes several matrices over the register port, streams directed and random
// vector words under varied idling and back-pressure, and checks every result
// word against a predicted transform.
// ----------------------------------------------------------------------------
module tb_vertex_transform_4x4_top;
   import vt4_pkg::*;
   import vt4_tb_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   csr_word_type          pwdata;
   csr_word_type          prdata;
   logic                  pready;

   vt4_req_if req_bus ();
   vt4_rsp_if rsp_bus ();

   transform_scoreboard scoreboard = new();

   // Vector words waiting to be offered, and the idling of each side.
   vector_word_t vectors_to_send [$];
   int           sender_idle_pct   = 0;
   int           receiver_stall_pct = 0;
   int           hold_cycles       = 0;

   // A long hold-off is asked for by bumping the request count; the result
   // side picks up the length and counts the cycles down on its own.
   int           hold_request_len  = 0;
   int           hold_request_cnt  = 0;
   int           hold_served_cnt   = 0;

   vertex_transform_4x4_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Result side: a long hold-off when asked, otherwise random stalls.
   always @(negedge clock) begin
      if (hold_served_cnt != hold_request_cnt) begin
         hold_served_cnt = hold_request_cnt;
         hold_cycles     = hold_request_len;
      end
      if (hold_cycles > 0) begin
         rsp_bus.ready = 1'b0;
         hold_cycles--;
      end else begin
         rsp_bus.ready = ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Every accepted result word goes to the scoreboard.
   always @(posedge clock) begin
      result_word_t got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.out_x    = rsp_bus.out_x;
         got.out_y    = rsp_bus.out_y;
         got.out_z    = rsp_bus.out_z;
         got.out_w    = rsp_bus.out_w;
         got.overflow = rsp_bus.overflow;
         scoreboard.check_result(got);
      end
   end

   // One register write: setup cycle, then access cycle until pready.
   task automatic write_csr(matrix_reg_e idx, csr_word_type value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = CSR_ADDR_W'(int'(idx) << REG_ADDR_LSB);
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      scoreboard.set_matrix_reg(idx, value);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic write_matrix(csr_word_type words [REG_COUNT]);
      for (int i = 0; i < REG_COUNT; i++) begin
         write_csr(matrix_reg_e'(i), words[i]);
      end
   endtask

   // Fixed-point value with a bias toward the extremes and small magnitudes.
   function automatic entry_type random_q16();
      entry_type value;
      case ($urandom_range(9))
         0: value = SAT_MAX;
         1: value = SAT_MIN;
         2: value = '0;
         3: value = 32'sh0001_0000;
         4: value = -32'sh0001_0000;
         5, 6: value = entry_type'($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
         default: value = entry_type'($urandom);
      endcase
      return value;
   endfunction

   task automatic write_random_matrix();
      csr_word_type words [REG_COUNT];
      for (int i = 0; i < REG_COUNT; i++) begin
         words[i] = {random_q16(), random_q16()};
      end
      write_matrix(words);
   endtask

   function automatic void queue_vector(entry_type x, entry_type y, entry_type z,
                                        entry_type w, dims_type dims);
      vector_word_t v;
      v.vec_x = x;
      v.vec_y = y;
      v.vec_z = z;
      v.vec_w = w;
      v.dims  = dims;
      vectors_to_send.push_back(v);
   endfunction

   // Mostly legal dims, with out-of-range codes mixed in.
   function automatic void queue_random_vectors(int count);
      dims_type dims;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0) begin
            dims = dims_type'($urandom_range(7));
         end else begin
            dims = dims_type'($urandom_range(int'(DIMS_MAX), int'(DIMS_MIN)));
         end
         queue_vector(random_q16(), random_q16(), random_q16(), random_q16(), dims);
      end
   endfunction

   // Offers every queued word, holding each until it is accepted.
   task automatic send_vectors();
      vector_word_t v;
      while (vectors_to_send.size() != 0) begin
         @(negedge clock);
         if ($urandom_range(99) < sender_idle_pct) begin
            req_bus.valid = 1'b0;
         end else begin
            v = vectors_to_send.pop_front();
            req_bus.vec_x = v.vec_x;
            req_bus.vec_y = v.vec_y;
            req_bus.vec_z = v.vec_z;
            req_bus.vec_w = v.vec_w;
            req_bus.dims  = v.dims;
            req_bus.valid = 1'b1;
            do @(posedge clock); while (!req_bus.ready);
            scoreboard.note_vector(v);
         end
      end
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   // Waits until every result word is back, then lets the pipeline settle.
   task automatic wait_drained();
      while (scoreboard.pending() != 0) begin
         @(posedge clock);
      end
      repeat (NUM_STAGES + 2) @(posedge clock);
   endtask

   task automatic set_idling(int idle_pct, int stall_pct);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
   endtask

   initial begin
      csr_word_type words [REG_COUNT];
      int           spin;

      reset         = 1'b1;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      req_bus.valid = 1'b0;
      req_bus.vec_x = '0;
      req_bus.vec_y = '0;
      req_bus.vec_z = '0;
      req_bus.vec_w = '0;
      req_bus.dims  = DIMS_MAX;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // Identity matrix out of reset: every dims code and the field extremes.
      for (int d = 0; d < 8; d++) begin
         queue_vector(SAT_MAX, SAT_MIN, -32'sd1, 32'sd1, dims_type'(d));
      end
      queue_vector('0, '0, '0, '0, DIMS_MAX);
      queue_vector(-32'sd1, -32'sd1, -32'sd1, -32'sd1, DIMS_MAX);
      send_vectors();
      wait_drained();

      // Largest entries: most positive on the upper rows, most negative below.
      for (int i = 0; i < REG_COUNT; i++) begin
         words[i] = (i < 4) ? {SAT_MAX, SAT_MAX} : {SAT_MIN, SAT_MIN};
      end
      write_matrix(words);
      queue_vector(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, DIMS_MAX);
      queue_vector(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, DIMS_MAX);
      queue_vector(32'sd1, 32'sd1, 32'sd1, 32'sd1, DIMS_MAX);
      queue_vector(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, 3'd3);
      send_vectors();
      wait_drained();

      // Every entry one half: floor rounding and the exact saturation edges.
      for (int i = 0; i < REG_COUNT; i++) begin
         words[i] = 64'h0000_8000_0000_8000;
      end
      write_matrix(words);
      queue_vector(-32'sd1, '0, '0, '0, DIMS_MIN);
      queue_vector(32'sd1, '0, '0, '0, DIMS_MIN);
      queue_vector(SAT_MAX, SAT_MAX, '0, '0, DIMS_MIN);
      queue_vector(SAT_MAX, SAT_MAX, 32'sd1, '0, 3'd3);
      queue_vector(SAT_MAX, SAT_MAX, 32'sd2, '0, 3'd3);
      queue_vector(SAT_MIN, SAT_MIN, '0, '0, DIMS_MIN);
      queue_vector(SAT_MIN, SAT_MIN, -32'sd1, '0, 3'd3);
      send_vectors();
      wait_drained();

      // Random matrices, each phase under a different idling pattern.
      write_random_matrix();
      set_idling(0, 0);
      queue_random_vectors(90);
      send_vectors();
      wait_drained();

      write_random_matrix();
      set_idling(60, 0);
      queue_random_vectors(90);
      send_vectors();
      wait_drained();

      write_random_matrix();
      set_idling(0, 60);
      queue_random_vectors(90);
      send_vectors();
      wait_drained();

      write_random_matrix();
      set_idling(28, 28);
      queue_random_vectors(90);
      send_vectors();
      wait_drained();

      // Result side held off while words keep coming, so the input backs up.
      write_random_matrix();
      set_idling(0, 0);
      hold_request_len = 64;
      hold_request_cnt++;
      queue_random_vectors(60);
      send_vectors();
      wait_drained();

      // All entries at minus one step, then a last mixed stretch.
      for (int i = 0; i < REG_COUNT; i++) begin
         words[i] = '1;
      end
      write_matrix(words);
      set_idling(28, 28);
      queue_random_vectors(40);
      send_vectors();

      // Bounded final drain, then the verdict.
      spin = 0;
      while (scoreboard.pending() != 0 && spin < 5000) begin
         @(posedge clock);
         spin++;
      end
      repeat (NUM_STAGES * 2) @(posedge clock);
      scoreboard.check_drained();
      if (scoreboard.failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/vt4_pkg.sv
hdl/vt4_ifaces.sv
hdl/vt4_csr.sv
hdl/vt4_lane.sv
hdl/vt4_merge.sv
hdl/vertex_transform_4x4_top.sv
dv/vt4_tb_pkg.sv
dv/tb_vertex_transform_4x4_top.sv
